// ===== sv/nad_pkg.sv =====
// Shared constants for the neural activation unit with derivative.
package nad_pkg;

  localparam logic [1:0] MODE_FAST_SIG = 2'd0;
  localparam logic [1:0] MODE_SIGMOID  = 2'd1;
  localparam logic [1:0] MODE_RELU     = 2'd2;
  localparam logic [1:0] MODE_TANH     = 2'd3;

  localparam logic [1:0] MODE_RESET    = MODE_SIGMOID;

  localparam logic [12:0] Q_ONE        = 13'd4096;
  localparam int          QW           = 13;

endpackage

// ===== sv/neural_activation_with_derivative.sv =====
// Pipelined activation unit: fast sigmoid, sigmoid, ReLU, tanh with derivatives.
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+------------------------------
//  input   | in_valid, in_ready, x_value[15:0]         | in  | one pre-activation, Q4.12
//  config  | cfg_valid, cfg_ready, activation_mode[1:0]| in  | function select, reset sigmoid
//  output  | out_valid, out_ready, activation[15:0],   | out | activation Q4.12 and
//          | derivative[12:0]                          |     | derivative Q1.12
//
//  One beat per cycle while the output is not stalled; six front stages (lookup, table read,
//  interpolation, rounding, product, divider load), thirteen restoring divider stages
//  (one quotient bit each) and an output register.
//  The divider chain for the fast sigmoid quotients sets the latency.
//  A stalled output freezes every stage; in_ready follows the output register.
//  Synchronous reset clears all valid bits and loads the sigmoid mode.
module neural_activation_with_derivative #(
  parameter int SIGMOID_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] x_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         activation_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] activation,
  output logic [12:0]        derivative
);

  localparam int IW = $clog2(SIGMOID_SEGMENTS);
  localparam int RW = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int PW = 16 + IW;
  localparam int QW = nad_pkg::QW;

  // shift-subtract quotient for building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    logic [64:0]     rmd;
    longint unsigned quo;
    rmd = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rmd = {rmd[63:0], num[i]};
      if (rmd >= {1'b0, den}) begin
        rmd    = rmd - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [12:0] sig_entry(input int k);
    longint unsigned one;
    longint unsigned seg;
    longint unsigned kk;
    longint unsigned mag;
    longint unsigned e;
    longint unsigned term;
    longint unsigned den;
    longint unsigned v;
    longint unsigned n;
    logic            neg;
    one  = 64'd1 << 32;
    seg  = 64'(SIGMOID_SEGMENTS);
    kk   = 64'(k);
    neg  = (16 * kk) < (8 * seg);
    mag  = neg ? (8 * seg - 16 * kk) : (16 * kk - 8 * seg);
    e    = one;
    term = one;
    for (n = 1; n < 200 && term != 0; n++) begin
      term = udiv(term * mag, seg * n);
      e    = e + term;
    end
    den = e + one;
    if (neg) begin
      v = udiv(one * 8192 + den, 2 * den);
    end else begin
      v = udiv(e * 8192 + den, 2 * den);
    end
    return 13'(v);
  endfunction

  logic [12:0] rom_tbl [SIGMOID_SEGMENTS+1];

  for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_rom
    localparam logic [12:0] ENTRY = sig_entry(k);
    assign rom_tbl[k] = ENTRY;
  end

  logic [1:0] mode_reg;
  logic       adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= nad_pkg::MODE_RESET;
    end else if (cfg_valid) begin
      mode_reg <= activation_mode;
    end
  end

  // stage A: lookup address, |x| + 1
  logic signed [15:0] x2_sat;
  logic signed [15:0] lk;
  logic [15:0]        lk_u;
  logic [PW-1:0]      p_in;
  logic [15:0]        m_in;

  always_comb begin
    if (x_value[15] != x_value[14]) begin
      x2_sat = x_value[15] ? 16'sh8000 : 16'sh7fff;
    end else begin
      x2_sat = {x_value[14:0], 1'b0};
    end
    lk   = (mode_reg == nad_pkg::MODE_TANH) ? x2_sat : x_value;
    lk_u = {~lk[15], lk[14:0]};
    p_in = PW'(lk_u) * PW'(SIGMOID_SEGMENTS);
    m_in = x_value[15] ? 16'(-x_value) : x_value;
  end

  logic               a_v;
  logic [1:0]         a_mode;
  logic signed [15:0] a_x;
  logic [15:0]        a_d;
  logic [IW-1:0]      a_idx;
  logic [15:0]        a_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mode <= mode_reg;
      a_x    <= x_value;
      a_d    <= 16'(nad_pkg::Q_ONE) + m_in;
      a_idx  <= p_in[PW-1:16];
      a_t    <= p_in[15:0];
    end
  end

  // stage B: table read, (1+|x|)^2
  logic [12:0] rom_lo;
  logic [12:0] rom_hi;

  assign rom_lo = rom_tbl[RW'(a_idx)];
  assign rom_hi = rom_tbl[RW'(a_idx) + RW'(1)];

  logic               b_v;
  logic [1:0]         b_mode;
  logic signed [15:0] b_x;
  logic [15:0]        b_d;
  logic [31:0]        b_d2;
  logic [12:0]        b_lo;
  logic [12:0]        b_diff;
  logic [15:0]        b_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode <= a_mode;
      b_x    <= a_x;
      b_d    <= a_d;
      b_d2   <= 32'(a_d) * 32'(a_d);
      b_lo   <= rom_lo;
      b_diff <= rom_hi - rom_lo;
      b_t    <= a_t;
    end
  end

  // stage C: interpolation product
  logic               c_v;
  logic [1:0]         c_mode;
  logic signed [15:0] c_x;
  logic [15:0]        c_d;
  logic [31:0]        c_d2;
  logic [12:0]        c_lo;
  logic [28:0]        c_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mode <= b_mode;
      c_x    <= b_x;
      c_d    <= b_d;
      c_d2   <= b_d2;
      c_lo   <= b_lo;
      c_prod <= 29'(b_diff) * 29'(b_t);
    end
  end

  // stage D: round, clamp, select derivative operands
  logic [29:0]        rnd_sum;
  logic [13:0]        s_raw;
  logic [12:0]        s_val;
  logic signed [14:0] act3;
  logic [12:0]        m3;

  always_comb begin
    rnd_sum = 30'(c_prod) + 30'd32768;
    s_raw   = 14'(c_lo) + rnd_sum[29:16];
    s_val   = (s_raw > 14'(nad_pkg::Q_ONE)) ? nad_pkg::Q_ONE : s_raw[12:0];
    act3    = $signed({1'b0, s_val, 1'b0}) - 15'sd4096;
    m3      = act3[14] ? 13'(-act3) : act3[12:0];
  end

  logic               d_v;
  logic [1:0]         d_mode;
  logic signed [15:0] d_x;
  logic [15:0]        d_d;
  logic [31:0]        d_d2;
  logic signed [15:0] d_act;
  logic [12:0]        d_ma;
  logic [12:0]        d_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_mode <= c_mode;
      d_x    <= c_x;
      d_d    <= c_d;
      d_d2   <= c_d2;
      if (c_mode == nad_pkg::MODE_TANH) begin
        d_act <= {act3[14], act3};
        d_ma  <= m3;
        d_mb  <= m3;
      end else begin
        d_act <= {3'b000, s_val};
        d_ma  <= s_val;
        d_mb  <= nad_pkg::Q_ONE - s_val;
      end
    end
  end

  // stage E: derivative product
  logic               e_v;
  logic [1:0]         e_mode;
  logic signed [15:0] e_x;
  logic [15:0]        e_d;
  logic [31:0]        e_d2;
  logic signed [15:0] e_act;
  logic [25:0]        e_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mode <= d_mode;
      e_x    <= d_x;
      e_d    <= d_d;
      e_d2   <= d_d2;
      e_act  <= d_act;
      e_pr   <= 26'(d_ma) * 26'(d_mb);
    end
  end

  // stage F: finish table modes, load divider
  logic [26:0]        pr_rnd;
  logic [12:0]        pr_q;
  logic signed [15:0] f_act;
  logic [12:0]        f_der;
  logic               x_pos;
  logic [15:0]        e_m;

  always_comb begin
    pr_rnd = 27'(e_pr) + 27'd2048;
    pr_q   = pr_rnd[24:12];
    x_pos  = !e_x[15] && (e_x != 16'sd0);
    e_m    = e_d - 16'(nad_pkg::Q_ONE);
    unique case (e_mode)
      nad_pkg::MODE_RELU: begin
        f_act = x_pos ? e_x : 16'sd0;
        f_der = x_pos ? nad_pkg::Q_ONE : 13'd0;
      end
      nad_pkg::MODE_TANH: begin
        f_act = e_act;
        f_der = nad_pkg::Q_ONE - pr_q;
      end
      default: begin
        f_act = e_act;
        f_der = pr_q;
      end
    endcase
  end

  logic               dv_v    [QW+1];
  logic [1:0]         dv_mode [QW+1];
  logic               dv_neg  [QW+1];
  logic signed [15:0] dv_act  [QW+1];
  logic [12:0]        dv_der  [QW+1];
  logic [28:0]        dv_r1   [QW+1];
  logic [16:0]        dv_dd1  [QW+1];
  logic [12:0]        dv_q1   [QW+1];
  logic [37:0]        dv_r2   [QW+1];
  logic [32:0]        dv_dd2  [QW+1];
  logic [12:0]        dv_q2   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_mode[0] <= e_mode;
      dv_neg[0]  <= e_x[15];
      dv_act[0]  <= f_act;
      dv_der[0]  <= f_der;
      dv_r1[0]   <= {e_m, 13'd0} + 29'(e_d);
      dv_dd1[0]  <= {e_d, 1'b0};
      dv_q1[0]   <= 13'd0;
      dv_r2[0]   <= (38'd1 << 37) + 38'(e_d2);
      dv_dd2[0]  <= {e_d2, 1'b0};
      dv_q2[0]   <= 13'd0;
    end
  end

  // divider stages: one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [29:0] sh1;
    logic [44:0] sh2;
    logic        ge1;
    logic        ge2;

    always_comb begin
      sh1 = 30'(dv_dd1[k]) << B;
      sh2 = 45'(dv_dd2[k]) << B;
      ge1 = 30'(dv_r1[k]) >= sh1;
      ge2 = 45'(dv_r2[k]) >= sh2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_mode[k+1] <= dv_mode[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_act[k+1]  <= dv_act[k];
        dv_der[k+1]  <= dv_der[k];
        dv_dd1[k+1]  <= dv_dd1[k];
        dv_dd2[k+1]  <= dv_dd2[k];
        dv_r1[k+1]   <= ge1 ? 29'(30'(dv_r1[k]) - sh1) : dv_r1[k];
        dv_r2[k+1]   <= ge2 ? 38'(45'(dv_r2[k]) - sh2) : dv_r2[k];
        dv_q1[k+1]   <= dv_q1[k] | (13'(ge1) << B);
        dv_q2[k+1]   <= dv_q2[k] | (13'(ge2) << B);
      end
    end
  end

  // output register
  logic [1:0]         o_mode;
  logic signed [15:0] fs_act;

  assign fs_act = dv_neg[QW] ? -$signed({3'b000, dv_q1[QW]}) : $signed({3'b000, dv_q1[QW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mode <= dv_mode[QW];
      if (dv_mode[QW] == nad_pkg::MODE_FAST_SIG) begin
        activation <= fs_act;
        derivative <= dv_q2[QW];
      end else begin
        activation <= dv_act[QW];
        derivative <= dv_der[QW];
      end
    end
  end

  a_der_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> derivative <= nad_pkg::Q_ONE)
    else $error("derivative above one");

  a_relu_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_mode == nad_pkg::MODE_RELU |-> !activation[15])
    else $error("relu activation negative");

  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_mode == nad_pkg::MODE_SIGMOID |->
      activation >= 16'sd0 && activation <= 16'sd4096)
    else $error("sigmoid activation out of range");

  a_tanh_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (o_mode == nad_pkg::MODE_TANH || o_mode == nad_pkg::MODE_FAST_SIG) |->
      activation >= -16'sd4096 && activation <= 16'sd4096)
    else $error("bounded activation out of range");

endmodule
